// File: sv/indexed_pixel_palette_expand_unit_defines.svh
// assertion macros for the indexed pixel palette expand unit
`ifndef INDEXED_PIXEL_PALETTE_EXPAND_UNIT_DEFINES_SVH
`define INDEXED_PIXEL_PALETTE_EXPAND_UNIT_DEFINES_SVH
`ifndef SYNTH
`define IPPE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IPPE_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define IPPE_ASSERT(lbl, clk, rst, prop, msg)
`define IPPE_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// File: sv/ippe_pkg.sv
// shared types and constants of the indexed pixel palette expand unit
package ippe_pkg;

  localparam int ACC_W   = 13;
  localparam int HELD_W  = 4;
  localparam int IDX_W   = 6;
  localparam int COLOR_W = 24;
  localparam int CNT_W   = 4;
  localparam int BPP_W   = 3;
  localparam int MODE_W  = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [MODE_W-1:0] MODE_1BPP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_2BPP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_3BPP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_4BPP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_6BPP = 3'd4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  typedef struct packed {
    logic               is_data;
    logic               fend;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
    logic [ACC_W-1:0]   acc;
    logic [HELD_W-1:0]  total;
    logic [BPP_W-1:0]   bpp;
    logic [CNT_W-1:0]   cnt;
  } job_t;

  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] left_cnt;
  } back_status_t;

endpackage

// File: sv/ippe_front.sv
// front end: accepts requests, runs the bit accumulator, builds jobs
module ippe_front import ippe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic [COLOR_W-1:0] entry_color,
  input  logic [7:0]         packed_byte,
  input  logic               frame_end,
  input  logic               cfg_valid,
  input  logic [MODE_W-1:0]  cfg_data,
  input  logic               queue_full,
  output logic               push,
  output job_t               job
);

  logic [MODE_W-1:0] depth_mode;
  logic [ACC_W-1:0]  acc;
  logic [HELD_W-1:0] held;

  logic [ACC_W-1:0]  acc_new;
  logic [ACC_W-1:0]  acc_keep;
  logic [4:0]        total5;
  logic [HELD_W-1:0] total;
  logic [BPP_W-1:0]  bpp;
  logic [CNT_W-1:0]  cnt;
  logic [HELD_W-1:0] left;
  logic [7:0]        prod3;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    acc_new = {acc[ACC_W-9:0], packed_byte};
    total5  = {1'b0, held} + 5'd8;
    total   = (total5 > 5'd13) ? 4'd13 : total5[3:0];
    prod3   = {4'd0, total} * 8'd11;
    unique case (depth_mode)
      MODE_2BPP: begin
        bpp  = 3'd2;
        cnt  = {1'b0, total[3:1]};
        left = {3'd0, total[0]};
      end
      MODE_3BPP: begin
        bpp  = 3'd3;
        cnt  = prod3[7:5] == 3'd0 ? 4'd0 : {1'b0, prod3[7:5]};
        left = total - cnt * 4'd3;
      end
      MODE_4BPP: begin
        bpp  = 3'd4;
        cnt  = {2'd0, total[3:2]};
        left = {2'd0, total[1:0]};
      end
      MODE_6BPP: begin
        bpp  = 3'd6;
        cnt  = (total >= 4'd12) ? 4'd2 : 4'd1;
        left = total - ((total >= 4'd12) ? 4'd12 : 4'd6);
      end
      default: begin
        bpp  = 3'd1;
        cnt  = (total > 4'd8) ? 4'd8 : total;
        left = total - cnt;
      end
    endcase
    acc_keep = acc_new & ((13'd1 << left) - 13'd1);

    job.is_data = (func == FUNC_DATA);
    job.fend    = frame_end;
    job.index   = entry_index;
    job.color   = entry_color;
    job.acc     = acc_new;
    job.total   = total;
    job.bpp     = bpp;
    job.cnt     = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= MODE_1BPP;
      acc        <= '0;
      held       <= '0;
    end else if (cfg_valid) begin
      depth_mode <= cfg_data;
      acc        <= '0;
      held       <= '0;
    end else if (push && func == FUNC_DATA) begin
      if (frame_end) begin
        acc  <= '0;
        held <= '0;
      end else begin
        acc  <= acc_keep;
        held <= left;
      end
    end
  end

endmodule

// File: sv/ippe_queue.sv
// short job queue between front and back
module ippe_queue import ippe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/ippe_back.sv
// back end: palette memory and per-pixel sequencer with output register
module ippe_back import ippe_pkg::*; #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  job_t         head,
  output logic         pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata,
  output logic         m_tlast,
  output logic         m_tuser,
  output back_status_t status
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [COLOR_W-1:0] palette [PALETTE_DEPTH];

  logic               out_valid;
  logic               active;
  logic [HELD_W-1:0]  cur_held;
  logic [CNT_W-1:0]   left_cnt;
  logic [COLOR_W-1:0] rgb_q;
  logic               oor_q;
  logic               run_last_q;
  logic               frame_last_q;

  logic [HELD_W-1:0]  eff_held;
  logic [CNT_W-1:0]   eff_left;
  logic [HELD_W-1:0]  shift;
  logic [ACC_W-1:0]   shifted;
  logic [6:0]         mask;
  logic [IDX_W-1:0]   idx;
  logic               issue;
  logic               advance;
  logic               last_pix;
  logic               rd_in_range;
  logic               wr_en;

  always_comb begin
    eff_held    = active ? cur_held : head.total;
    eff_left    = active ? left_cnt : head.cnt;
    shift       = eff_held - {1'b0, head.bpp};
    shifted     = head.acc >> shift;
    mask        = (7'd1 << head.bpp) - 7'd1;
    idx         = shifted[IDX_W-1:0] & mask[IDX_W-1:0];
    issue       = head_valid && head.is_data;
    advance     = !out_valid || m_tready;
    last_pix    = (eff_left == 4'd1);
    pop         = head_valid && (!head.is_data || (advance && last_pix));
    rd_in_range = ({1'b0, idx} < 7'(PALETTE_DEPTH));
    wr_en       = head_valid && !head.is_data && ({1'b0, head.index} < 7'(PALETTE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette[head.index[AW-1:0]] <= head.color;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && issue) begin
      rgb_q        <= palette[idx[AW-1:0]];
      oor_q        <= !rd_in_range;
      run_last_q   <= last_pix;
      frame_last_q <= last_pix && head.fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
      cur_held  <= '0;
      left_cnt  <= '0;
    end else if (advance) begin
      out_valid <= issue;
      if (issue) begin
        if (last_pix) begin
          active <= 1'b0;
        end else begin
          active   <= 1'b1;
          cur_held <= shift;
          left_cnt <= eff_left - 4'd1;
        end
      end
    end
  end

  assign m_tvalid        = out_valid;
  assign m_tdata         = oor_q ? 24'd0 : {rgb_q[7:0], rgb_q[15:8], rgb_q[23:16]};
  assign m_tlast         = run_last_q;
  assign m_tuser         = frame_last_q;
  assign status.active   = active;
  assign status.left_cnt = left_cnt;

endmodule

// File: sv/indexed_pixel_palette_expand_unit.sv
// top level of the indexed pixel palette expand unit
// Expands packed palette indices (1, 2, 3, 4 or 6 bpp, msb first) into 24-bit rgb.
// Each request is either a palette entry write or one data byte; a data byte
// gives one to eight pixels, the last marked on tlast, and on tuser as well when
// the byte closed a frame. The front end takes one request per cycle while its
// four-entry job queue has room. The back end sends one pixel per cycle while
// the receiver is ready, a rate that the single palette read port sets; a data
// byte gives eight pixels at 1 bpp and one or two at 6 bpp. Pixels leave from a
// registered output stage that captures the palette read. depth_mode is written
// over the cfg channel, which clears any leftover bits; the user must write it
// only while idle, the block itself does not enforce this.
`include "indexed_pixel_palette_expand_unit_defines.svh"
module indexed_pixel_palette_expand_unit import ippe_pkg::*; #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // entry_index[5:0], entry_color[29:6], packed_byte[37:30], zero
  input  logic        s_tuser,   // func
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_tuser,   // frame_last
  output logic        m_tlast,   // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data   // depth_mode
);

  logic         push;
  job_t         push_job;
  logic         q_full;
  logic         head_valid;
  job_t         head;
  logic         pop;
  back_status_t back_status;

  assign cfg_ready = 1'b1;

  ippe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .func        (s_tuser),
    .entry_index (s_tdata[5:0]),
    .entry_color (s_tdata[29:6]),
    .packed_byte (s_tdata[37:30]),
    .frame_end   (s_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .queue_full  (q_full),
    .push        (push),
    .job         (push_job)
  );

  ippe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ippe_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .status     (back_status)
  );

  `IPPE_ASSERT(a_frame_implies_run, clk, rst, m_tvalid && m_tuser |-> m_tlast, "frame_last without run_last")
  `IPPE_ASSERT_NEVER(a_active_count, clk, rst, back_status.active && (back_status.left_cnt == 4'd0 || back_status.left_cnt > 4'd7), "pixel count out of range while active")
  `IPPE_ASSERT(a_push_lands, clk, rst, s_tvalid && s_tready && !rst |=> head_valid, "accepted request missing from queue")

endmodule

// File: tb/sv/indexed_pixel_palette_expand_unit_tb.sv
// self-checking testbench for the indexed pixel palette expand unit
module indexed_pixel_palette_expand_unit_tb;
  import ippe_pkg::*;

  localparam int PAL_DEPTH     = 64;
  localparam int DIR_ROWS      = 27;
  localparam int SEG_ITEMS     = 80;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_LEN      = 300;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [MODE_W-1:0] MODE_UNUSED5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED7 = 3'd7;

  typedef struct packed {
    logic               func;
    logic [IDX_W-1:0]   entry;
    logic [COLOR_W-1:0] color;
    logic [7:0]         pbyte;
    logic               fend;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_last;
    logic       frame_last;
  } pixel_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               func;
    logic [IDX_W-1:0]   entry;
    logic [COLOR_W-1:0] color;
    logic [7:0]         pbyte;
    logic               fend;
    logic [MODE_W-1:0]  mode;
    bit                 typed;
    logic [COLOR_W-1:0] exp_rgb;
    int                 exp_n;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;

  indexed_pixel_palette_expand_unit #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [COLOR_W-1:0] pal_color [PAL_DEPTH];
  bit                 pal_valid [PAL_DEPTH];
  logic [ACC_W-1:0]   pend_bits = '0;
  logic [HELD_W-1:0]  pend_cnt = '0;
  logic [MODE_W-1:0]  cur_mode = MODE_1BPP;

  int unsigned        split_ix [8];
  int unsigned        split_n;
  logic [ACC_W-1:0]   split_acc;
  logic [HELD_W-1:0]  split_held;

  pixel_t pending_pixels [$];
  pixel_t got_px;
  pixel_t want_px;
  int     mismatch_cnt = 0;
  int     cycle_cnt = 0;
  int     tx_idle_pct = 15;
  int     rx_idle_pct = 75;
  bit     hold_go = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_left = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_REQ, FUNC_WRITE, 6'd0,  24'h000000, 8'hFF, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_WRITE, 6'd1,  24'hFFFFFF, 8'h00, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_DATA,  6'd63, 24'hFFFFFF, 8'hFF, 1'b0, MODE_1BPP, 1'b1, 24'hFFFFFF, 8},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b1, MODE_1BPP, 1'b1, 24'h000000, 8},
    // frame end on a palette write is ignored
    '{ROW_REQ, FUNC_WRITE, 6'd63, 24'hA5C3E1, 8'hFF, 1'b1, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_WRITE, 6'd2,  24'h123456, 8'h00, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_WRITE, 6'd3,  24'h654321, 8'h00, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_CFG, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b0, MODE_2BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'hFF, 1'b0, MODE_1BPP, 1'b1, 24'h654321, 4},
    '{ROW_REQ, FUNC_DATA,  6'd5,  24'h5A5A5A, 8'h1B, 1'b1, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_WRITE, 6'd7,  24'h00FF00, 8'h00, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_WRITE, 6'd6,  24'h0000FF, 8'h00, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_CFG, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b0, MODE_3BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'hFF, 1'b0, MODE_1BPP, 1'b1, 24'h00FF00, 2},
    // leftover bits span into this byte, the last one is dropped
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b1, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_WRITE, 6'd48, 24'h30C030, 8'h00, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_WRITE, 6'd15, 24'h13579B, 8'h00, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_CFG, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b0, MODE_6BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'hFF, 1'b0, MODE_1BPP, 1'b1, 24'hA5C3E1, 1},
    // same depth written again, leftover bits must be gone
    '{ROW_CFG, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b0, MODE_6BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b0, MODE_1BPP, 1'b1, 24'h000000, 1},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'hFF, 1'b0, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'hFF, 1'b1, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_CFG, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b0, MODE_4BPP, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'hF0, 1'b1, MODE_1BPP, 1'b0, 24'h0, 0},
    '{ROW_CFG, FUNC_DATA,  6'd0,  24'h000000, 8'h00, 1'b0, MODE_UNUSED7, 1'b0, 24'h0, 0},
    '{ROW_REQ, FUNC_DATA,  6'd0,  24'h000000, 8'h80, 1'b1, MODE_1BPP, 1'b0, 24'h0, 0}
  };

  function automatic int unsigned depth_bits(input logic [MODE_W-1:0] m);
    case (m)
      MODE_2BPP: return 2;
      MODE_3BPP: return 3;
      MODE_4BPP: return 4;
      MODE_6BPP: return 6;
      default:   return 1;
    endcase
  endfunction

  // indices a data byte yields from the current accumulator, nothing committed
  function automatic void unpack_indices(input logic [7:0] b);
    int unsigned a;
    int unsigned h;
    int unsigned w;
    int unsigned sh;
    a = ((pend_bits << 8) | b) & 32'h1FFF;
    h = pend_cnt + 8;
    if (h > ACC_W) h = ACC_W;
    w = depth_bits(cur_mode);
    split_n = 0;
    while (h >= w && split_n < 8) begin
      sh = h - w;
      split_ix[split_n] = (a >> sh) & ((32'd1 << w) - 1);
      h = sh;
      a = a & ((32'd1 << sh) - 1);
      split_n++;
    end
    split_acc = ACC_W'(a);
    split_held = HELD_W'(h);
  endfunction

  function automatic pixel_t pixel_of(input logic [COLOR_W-1:0] rgb, input bit last,
                                      input logic fend);
    pixel_t p;
    p.red = rgb[23:16];
    p.green = rgb[15:8];
    p.blue = rgb[7:0];
    p.run_last = last;
    p.frame_last = last & fend;
    return p;
  endfunction

  function automatic void expand_request(input req_t r, input bit typed,
                                         input logic [COLOR_W-1:0] t_rgb, input int t_n);
    logic [COLOR_W-1:0] rgb;
    if (r.func == FUNC_WRITE) begin
      if (r.entry < PAL_DEPTH) begin
        pal_color[r.entry] = r.color;
        pal_valid[r.entry] = 1'b1;
      end
    end else begin
      unpack_indices(r.pbyte);
      if (typed) begin
        for (int k = 0; k < t_n; k++)
          pending_pixels.push_back(pixel_of(t_rgb, k == t_n - 1, r.fend));
      end else begin
        for (int unsigned k = 0; k < split_n; k++) begin
          rgb = (split_ix[k] < PAL_DEPTH) ? pal_color[split_ix[k]] : '0;
          pending_pixels.push_back(pixel_of(rgb, k == split_n - 1, r.fend));
        end
      end
      pend_bits = r.fend ? '0 : split_acc;
      pend_cnt = r.fend ? '0 : split_held;
    end
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.func = 1'($urandom_range(0, 1));
    r.entry = 6'($urandom_range(0, 63));
    r.color = 24'($urandom_range(0, 24'hFFFFFF));
    r.pbyte = 8'($urandom_range(0, 255));
    r.fend = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_req(input req_t r, input bit typed, input logic [COLOR_W-1:0] t_rgb,
                          input int t_n);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, r.pbyte, r.color, r.entry};
    s_tuser <= r.func;
    s_tlast <= r.fend;
    do @(posedge clk); while (!s_tready);
    expand_request(r, typed, t_rgb, t_n);
  endtask

  // write every entry the byte would read that holds no color yet
  task automatic load_missing_entries(input logic [7:0] b);
    req_t wr;
    int   miss;
    do begin
      unpack_indices(b);
      miss = -1;
      for (int unsigned k = 0; k < split_n; k++)
        if (miss < 0 && split_ix[k] < PAL_DEPTH && !pal_valid[split_ix[k]])
          miss = split_ix[k];
      if (miss >= 0) begin
        wr = rand_req();
        wr.func = FUNC_WRITE;
        wr.entry = IDX_W'(miss);
        send_req(wr, 1'b0, '0, 0);
      end
    end while (miss >= 0);
  endtask

  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_depth_mode(input logic [MODE_W-1:0] m);
    drain_pixels();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
    pend_bits = '0;
    pend_cnt = '0;
  endtask

  task automatic run_segment(input int n_items, input bit press);
    req_t rq;
    int   sent;
    int   len;
    if ($urandom_range(0, 3) == 0) set_depth_mode(MODE_W'($urandom_range(5, 7)));
    else set_depth_mode(MODE_W'($urandom_range(0, 4)));
    if (press) hold_go = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 10) begin
        rq = rand_req();
        rq.func = FUNC_WRITE;
        send_req(rq, 1'b0, '0, 0);
        sent++;
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          rq = rand_req();
          rq.func = FUNC_DATA;
          // mostly whole frames, now and then an early or a missing frame end
          if (k == len - 1) rq.fend = ($urandom_range(0, 99) < 85);
          else rq.fend = ($urandom_range(0, 99) < 5);
          load_missing_entries(rq.pbyte);
          send_req(rq, 1'b0, '0, 0);
          sent++;
        end
      end
    end
  endtask

  // receiver side, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_px.red = m_tdata[7:0];
      got_px.green = m_tdata[15:8];
      got_px.blue = m_tdata[23:16];
      got_px.run_last = m_tlast;
      got_px.frame_last = m_tuser;
      if (pending_pixels.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected pixel: r=%h g=%h b=%h run_last=%b frame_last=%b",
                   got_px.red, got_px.green, got_px.blue, got_px.run_last,
                   got_px.frame_last);
      end else begin
        want_px = pending_pixels.pop_front();
        if (got_px !== want_px) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("pixel mismatch: expected r=%h g=%h b=%h run_last=%b frame_last=%b, actual r=%h g=%h b=%h run_last=%b frame_last=%b",
                     want_px.red, want_px.green, want_px.blue, want_px.run_last,
                     want_px.frame_last, got_px.red, got_px.green, got_px.blue,
                     got_px.run_last, got_px.frame_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim
    req_t rq;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 15;
    rx_idle_pct = 75;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        set_depth_mode(dir_tab[i].mode);
      end else begin
        rq.func = dir_tab[i].func;
        rq.entry = dir_tab[i].entry;
        rq.color = dir_tab[i].color;
        rq.pbyte = dir_tab[i].pbyte;
        rq.fend = dir_tab[i].fend;
        send_req(rq, dir_tab[i].typed, dir_tab[i].exp_rgb, dir_tab[i].exp_n);
      end
    end
    run_segment(SEG_ITEMS, 1'b0);
    run_segment(SEG_ITEMS, 1'b0);

    tx_idle_pct = 75;
    rx_idle_pct = 15;
    set_depth_mode(MODE_UNUSED5);
    run_segment(SEG_ITEMS, 1'b0);
    run_segment(SEG_ITEMS, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_segment(SEG_ITEMS, 1'b1);
    run_segment(SEG_ITEMS, 1'b0);

    drain_pixels();
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
